// ===== sv/life_generation_stencil_defines.svh =====
// Assertion macros shared by the life generation stencil RTL.
`ifndef LIFE_GENERATION_STENCIL_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LGS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life_generation_stencil: assertion failed");

// Next-cycle implication, checked outside reset.
`define LGS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life_generation_stencil: assertion failed");

`endif

// ===== sv/lgs_pkg.sv =====
// Package with the constants, types and rule tables of the life generation stencil.
package lgs_pkg;

    localparam int MAX_COLS  = 2048;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 2);

    localparam int CFG_COLS_W = 12;
    localparam int CFG_ROWS_W = 11;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_ROW_W  = 10;
    localparam int OUT_COL_W  = 11;
    localparam int NBR_W      = 4;

    localparam logic [CFG_COLS_W-1:0] RESET_COLS = CFG_COLS_W'(MAX_COLS);
    localparam logic [CFG_ROWS_W-1:0] RESET_ROWS = CFG_ROWS_W'(MAX_ROWS);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOARD_COLS = 2'd0,
        REG_BOARD_ROWS = 2'd1
    } t_reg_idx;

    // B3S23: indexed by the live neighbor count.
    localparam logic [8:0] BIRTH_RULE   = 9'b0_0000_1000;
    localparam logic [8:0] SURVIVE_RULE = 9'b0_0000_1100;

    typedef struct packed {
        logic up;
        logic down;
        logic off;
        logic skip_centre;
    } t_cell_mask;

    typedef struct packed {
        logic                 next_alive;
        logic [OUT_ROW_W-1:0] cell_row;
        logic [OUT_COL_W-1:0] cell_col;
        logic                 last_cell;
    } t_result;

endpackage

// ===== sv/lgs_ifs.sv =====
// Channel interfaces of the life generation stencil: configuration, cell input, result output.
interface lgs_cfg_if import lgs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface lgs_cell_if ();
    logic valid;
    logic ready;
    logic cell_alive;
    logic is_flush;

    modport source (output valid, output cell_alive, output is_flush, input ready);
    modport sink (input valid, input cell_alive, input is_flush, output ready);
endinterface

interface lgs_result_if import lgs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 next_alive;
    logic [OUT_ROW_W-1:0] cell_row;
    logic [OUT_COL_W-1:0] cell_col;
    logic                 last_cell;

    modport source (output valid, output next_alive, output cell_row, output cell_col,
                    output last_cell, input ready);
    modport sink (input valid, input next_alive, input cell_row, input cell_col,
                  input last_cell, output ready);
endinterface

// ===== sv/lgs_line_store.sv =====
// Two-row line store: one 2-bit entry per column, registered read with write bypass.
module lgs_line_store import lgs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    output logic [1:0]       o_rd_data,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  logic [1:0]       i_wr_data
);

    logic [1:0] r_mem [MAX_COLS];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A write to the address being read in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/lgs_col_cell.sv =====
// One column cell of the 3x3 window: holds three rows and counts the column shifting in.
module lgs_col_cell import lgs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic [2:0] i_col,
    input  t_cell_mask i_mask,
    output logic [2:0] o_col,
    output logic [1:0] o_count
);

    logic [2:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 3'b000;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    // Bit 0 is the row above, bit 1 the middle row, bit 2 the row below.
    always_comb begin
        if (i_mask.off) begin
            o_count = 2'd0;
        end else begin
            o_count = 2'(i_col[0] & ~i_mask.up)
                    + 2'(i_col[1] & ~i_mask.skip_centre)
                    + 2'(i_col[2] & ~i_mask.down);
        end
    end

    assign o_col = r_col;

endmodule

// ===== sv/lgs_out_fifo.sv =====
// Small result queue that decouples the stencil pipeline from the output handshake.
module lgs_out_fifo import lgs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output t_result               o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + FIFO_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== sv/life_generation_stencil.sv =====
// Top level of the life generation stencil: one B3S23 generation over a raster cell stream.
//
// The block takes one board cell per clock cycle in raster order on i_cell and returns the next
// generation of each cell on o_result, with its row, its column and a flag on the final cell of
// the board. A cell enters at stream position p; the cell p - (board_cols + 1) leaves once p has
// reached board_cols + 1, so after the board the host sends board_cols + 1 flush transactions
// that stand for dead cells, and the last of them brings out the final cell. Cells outside the
// board count as dead. Sustained rate is one input transaction per clock while input ready is
// high; a result passes through the stage-one register and the result queue on its way to
// o_result. The line store has a registered read port: the cell is read in the accept cycle
// and written back in the next, with a bypass so that one-column boards keep the same rate.
// Input ready drops only while the four-entry result queue, counting the result still in the
// pipeline, is full. Writing board_cols or board_rows starts a new board; the line store and
// window need no clearing, because every neighbor outside the current board is masked by
// position.
`include "life_generation_stencil_defines.svh"

module life_generation_stencil import lgs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lgs_cfg_if.sink      i_cfg,
    lgs_cell_if.sink     i_cell,
    lgs_result_if.source o_result
);

    // Stage-one payload: what the accept cycle knows about the cell that is leaving.
    typedef struct packed {
        logic                 emit;
        logic                 alive;
        logic [COL_W-1:0]     addr;
        logic [ROW_CNT_W-1:0] row;
        logic [COL_W-1:0]     col;
        logic                 last;
        logic                 m_up;
        logic                 m_down;
        logic                 m_left;
        logic                 m_right;
    } t_stage;

    // Configuration. Values are stored already clamped to the legal range.
    logic                  w_cfg_acc;
    logic                  w_size_wr;
    logic [CFG_COLS_W-1:0] r_cols;
    logic [CFG_ROWS_W-1:0] r_rows;
    logic [CFG_COLS_W-1:0] w_cfg_cols;
    logic [CFG_ROWS_W-1:0] w_cfg_rows;

    // Stream position of the next input, kept as row and column.
    logic [COL_W-1:0]     r_pc;
    logic [ROW_CNT_W-1:0] r_pr;
    logic                 w_acc;
    logic                 w_last;
    logic                 w_col_wrap;
    logic                 w_pc_nz;
    logic [ROW_CNT_W-1:0] w_rows_ext;

    t_stage n_s1;
    t_stage r_s1;
    logic   r_s1_valid;

    logic [1:0]       w_ls_rd;
    logic [2:0]       w_col3;
    logic [2:0]       w_col_c;
    logic [2:0]       w_col_l;
    logic [2:0]       w_col_far;
    logic [1:0]       w_cnt_r;
    logic [1:0]       w_cnt_c;
    logic [1:0]       w_cnt_l;
    logic [NBR_W-1:0] w_nbr;
    logic             w_self;
    t_cell_mask       w_mask_r;
    t_cell_mask       w_mask_c;
    t_cell_mask       w_mask_l;

    logic                  w_push;
    t_result               w_result;
    t_result               w_out;
    logic [FIFO_CNT_W-1:0] w_fifo_count;
    logic                  w_fifo_valid;

    // ---------------- Configuration port ----------------
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    // Either board size write restarts the stream position.
    assign w_size_wr   = w_cfg_acc && (i_cfg.index == REG_BOARD_COLS ||
                                       i_cfg.index == REG_BOARD_ROWS);

    // A zero acts as one; a value above the maximum acts as the maximum.
    always_comb begin
        w_cfg_cols = i_cfg.data[CFG_COLS_W-1:0];
        if (w_cfg_cols == '0) begin
            w_cfg_cols = CFG_COLS_W'(1);
        end else if (w_cfg_cols > CFG_COLS_W'(MAX_COLS)) begin
            w_cfg_cols = CFG_COLS_W'(MAX_COLS);
        end
        w_cfg_rows = i_cfg.data[CFG_ROWS_W-1:0];
        if (w_cfg_rows == '0) begin
            w_cfg_rows = CFG_ROWS_W'(1);
        end else if (w_cfg_rows > CFG_ROWS_W'(MAX_ROWS)) begin
            w_cfg_rows = CFG_ROWS_W'(MAX_ROWS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= RESET_COLS;
            r_rows <= RESET_ROWS;
        end else if (w_cfg_acc) begin
            unique case (i_cfg.index)
                REG_BOARD_COLS: r_cols <= w_cfg_cols;
                REG_BOARD_ROWS: r_rows <= w_cfg_rows;
                default: ;
            endcase
        end
    end

    // ---------------- Stream position ----------------
    assign w_acc      = i_cell.valid && i_cell.ready;
    assign w_rows_ext = ROW_CNT_W'(r_rows);
    assign w_pc_nz    = (r_pc != '0);
    // The final flush transaction sits at position (rows + 1) * cols.
    assign w_last     = (r_pr == w_rows_ext + ROW_CNT_W'(1)) && !w_pc_nz;
    assign w_col_wrap = (CFG_COLS_W'(r_pc) + CFG_COLS_W'(1)) == r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_pr <= '0;
        end else if (w_size_wr) begin
            r_pc <= '0;
            r_pr <= '0;
        end else if (w_acc) begin
            if (w_last) begin
                r_pc <= '0;
                r_pr <= '0;
            end else if (w_col_wrap) begin
                r_pc <= '0;
                r_pr <= r_pr + ROW_CNT_W'(1);
            end else begin
                r_pc <= r_pc + COL_W'(1);
            end
        end
    end

    // The leaving cell is one row up and one column left of the entering one.
    always_comb begin
        n_s1.emit  = (r_pr > ROW_CNT_W'(1)) || ((r_pr == ROW_CNT_W'(1)) && w_pc_nz);
        n_s1.alive = i_cell.cell_alive && !i_cell.is_flush && (r_pr < w_rows_ext);
        n_s1.addr  = r_pc;
        n_s1.last  = w_last;
        if (w_pc_nz) begin
            n_s1.col = r_pc - COL_W'(1);
            n_s1.row = r_pr - ROW_CNT_W'(1);
        end else begin
            n_s1.col = COL_W'(r_cols - CFG_COLS_W'(1));
            n_s1.row = r_pr - ROW_CNT_W'(2);
        end
        n_s1.m_up    = (n_s1.row == '0);
        n_s1.m_down  = (n_s1.row + ROW_CNT_W'(1)) >= w_rows_ext;
        n_s1.m_left  = (n_s1.col == '0);
        n_s1.m_right = (CFG_COLS_W'(n_s1.col) + CFG_COLS_W'(1)) == r_cols;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- Line store ----------------
    lgs_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc),
        .i_rd_addr (r_pc),
        .o_rd_data (w_ls_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1.addr),
        .i_wr_data ({w_ls_rd[0], r_s1.alive})
    );

    // New column: two rows up, one row up, and the entering cell.
    assign w_col3 = {r_s1.alive, w_ls_rd[0], w_ls_rd[1]};

    // ---------------- Window: a chain of three column cells ----------------
    assign w_mask_r = '{up: r_s1.m_up, down: r_s1.m_down, off: r_s1.m_right, skip_centre: 1'b0};
    assign w_mask_c = '{up: r_s1.m_up, down: r_s1.m_down, off: 1'b0, skip_centre: 1'b1};
    assign w_mask_l = '{up: r_s1.m_up, down: r_s1.m_down, off: r_s1.m_left, skip_centre: 1'b0};

    lgs_col_cell u_cell_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s1_valid),
        .i_col   (w_col3),
        .i_mask  (w_mask_r),
        .o_col   (w_col_c),
        .o_count (w_cnt_r)
    );

    lgs_col_cell u_cell_centre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s1_valid),
        .i_col   (w_col_c),
        .i_mask  (w_mask_c),
        .o_col   (w_col_l),
        .o_count (w_cnt_c)
    );

    // The column leaving the left cell is past the window and only checked below.
    lgs_col_cell u_cell_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s1_valid),
        .i_col   (w_col_l),
        .i_mask  (w_mask_l),
        .o_col   (w_col_far),
        .o_count (w_cnt_l)
    );

    assign w_nbr  = NBR_W'(w_cnt_r) + NBR_W'(w_cnt_c) + NBR_W'(w_cnt_l);
    assign w_self = w_col_c[1];

    always_comb begin
        w_result.next_alive = w_self ? SURVIVE_RULE[w_nbr] : BIRTH_RULE[w_nbr];
        w_result.cell_row   = OUT_ROW_W'(r_s1.row);
        w_result.cell_col   = OUT_COL_W'(r_s1.col);
        w_result.last_cell  = r_s1.last;
    end

    // ---------------- Result queue and handshakes ----------------
    assign w_push = r_s1_valid && r_s1.emit;

    // Room is reserved for the result still in stage one, so the pipeline never stalls.
    assign i_cell.ready = (w_fifo_count + FIFO_CNT_W'(w_push)) < FIFO_CNT_W'(FIFO_DEPTH);

    lgs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_pop   (w_fifo_valid && o_result.ready),
        .o_valid (w_fifo_valid),
        .o_data  (w_out),
        .o_count (w_fifo_count)
    );

    assign o_result.valid      = w_fifo_valid;
    assign o_result.next_alive = w_out.next_alive;
    assign o_result.cell_row   = w_out.cell_row;
    assign o_result.cell_col   = w_out.cell_col;
    assign o_result.last_cell  = w_out.last_cell;

    // ---------------- Assertions ----------------
    `LGS_ASSERT_IMP(a_fifo_room, i_clk, i_rst_n, w_push, w_fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
    `LGS_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pr <= w_rows_ext + ROW_CNT_W'(1))
    `LGS_ASSERT_NXT(a_board_wrap, i_clk, i_rst_n, w_acc && w_last, r_pr == '0 && r_pc == '0)
    `LGS_ASSERT_NXT(a_cfg_restart, i_clk, i_rst_n, w_size_wr, r_pr == '0 && r_pc == '0)
    `LGS_ASSERT_NXT(a_chain_shift, i_clk, i_rst_n, r_s1_valid, w_col_far == $past(w_col_l))

endmodule

// ===== tb/tb_life_generation_stencil.sv =====
// Self-checking testbench for the life generation stencil: streamed boards checked cell by cell.
`timescale 1ns / 100ps

module tb_life_generation_stencil import lgs_pkg::*; ();

    // Clock and synchronous active-low reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Channels into and out of the block.
    lgs_cfg_if    cfg_if ();
    lgs_cell_if   cell_if ();
    lgs_result_if res_if ();

    life_generation_stencil dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_cell   (cell_if),
        .o_result (res_if)
    );

    // Cell-level model of one Life generation. It mirrors the line store, the 3x3 window and
    // the stream position of the block, so every accepted cell transaction yields exactly the
    // result the block owes for it, which is queued until the output side delivers it.
    class next_gen_board;
        logic [CFG_COLS_W-1:0] cols_reg;
        logic [CFG_ROWS_W-1:0] rows_reg;
        logic [1:0]            line_store [MAX_COLS];
        logic [8:0]            window;
        int unsigned           stream_pos;
        t_result               pending_cells [$];
        int unsigned           cells_taken;
        int unsigned           results_seen;
        int unsigned           board_ends;
        int unsigned           live_out;
        int unsigned           mismatches;

        function new();
            cols_reg = RESET_COLS;
            rows_reg = RESET_ROWS;
            foreach (line_store[i]) line_store[i] = 2'b00;
            window       = '0;
            stream_pos   = 0;
            cells_taken  = 0;
            results_seen = 0;
            board_ends   = 0;
            live_out     = 0;
            mismatches   = 0;
        endfunction

        // A zero size acts as one, anything above the maximum acts as the maximum.
        static function int unsigned clamp_dim(int unsigned val, int unsigned hi);
            if (val == 0) return 1;
            if (val > hi) return hi;
            return val;
        endfunction

        // Any write to a board size starts a new board; the stores are left as they are.
        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BOARD_COLS: begin
                    cols_reg   = val[CFG_COLS_W-1:0];
                    stream_pos = 0;
                end
                REG_BOARD_ROWS: begin
                    rows_reg   = val[CFG_ROWS_W-1:0];
                    stream_pos = 0;
                end
                default: ;
            endcase
        endfunction

        function void take_cell(logic alive, logic flush);
            int unsigned cols_e, rows_e, total, last_pos, p, b, q, r, c, n;
            logic        v;
            logic [1:0]  ls;
            t_result     want;
            cols_e   = clamp_dim(cols_reg, MAX_COLS);
            rows_e   = clamp_dim(rows_reg, MAX_ROWS);
            total    = rows_e * cols_e;
            last_pos = total + cols_e;
            p        = (stream_pos > last_pos) ? 0 : stream_pos;
            b        = p % cols_e;
            cells_taken++;

            // Flush items and anything past the board enter as dead cells.
            v  = !flush && (p < total) && alive;
            ls = line_store[b];
            line_store[b] = {ls[0], v};
            // New window column: bit 0 two rows up, bit 1 one row up, bit 2 the new cell.
            window     = {window[5:0], v, ls[0], ls[1]};
            stream_pos = (p == last_pos) ? 0 : p + 1;

            if (p < cols_e + 1) return;

            q = p - cols_e - 1;
            r = q / cols_e;
            c = q % cols_e;
            n = 0;
            // Window bit 3*dc+dr: dc 0 right, 1 center, 2 left; dr 0 up, 1 center, 2 down.
            for (int dc = 0; dc < 3; dc++) begin
                for (int dr = 0; dr < 3; dr++) begin
                    if ((dc == 1 && dr == 1) || (dc == 0 && c + 1 >= cols_e) ||
                        (dc == 2 && c == 0) || (dr == 0 && r == 0) ||
                        (dr == 2 && r + 1 >= rows_e)) continue;
                    n += window[3 * dc + dr];
                end
            end
            want.next_alive = (n == 3) || (window[4] && n == 2);
            want.cell_row   = OUT_ROW_W'(r);
            want.cell_col   = OUT_COL_W'(c);
            want.last_cell  = (p == last_pos);
            pending_cells.push_back(want);
        endfunction

        function void check_cell(t_result got);
            t_result want;
            results_seen++;
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: alive %0d row %0d col %0d last %0d",
                             $time, got.next_alive, got.cell_row, got.cell_col, got.last_cell);
                return;
            end
            want = pending_cells.pop_front();
            if (got.next_alive !== want.next_alive || got.cell_row !== want.cell_row ||
                got.cell_col !== want.cell_col || got.last_cell !== want.last_cell) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch: expected alive %0d row %0d col %0d last %0d",
                             $time, want.next_alive, want.cell_row, want.cell_col,
                             want.last_cell);
                    $display("    got alive %0d row %0d col %0d last %0d",
                             got.next_alive, got.cell_row, got.cell_col, got.last_cell);
                end
            end else begin
                if (got.last_cell) board_ends++;
                if (got.next_alive) live_out++;
            end
        endfunction
    endclass

    next_gen_board life_sb = new();

    // Idle rates in percent for the cell sender and the result receiver.
    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 56;

    // Stimulus-side bookkeeping: effective board size and transaction counts.
    int unsigned board_w    = MAX_COLS;
    int unsigned board_h    = MAX_ROWS;
    int unsigned items_sent = 0;
    int unsigned boards_run = 0;

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        res_if.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: every transaction is sampled at the clock edge that completes it, so the
    // model sees register writes, accepted cells and delivered results in handshake order.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                life_sb.write_reg(t_reg_idx'(cfg_if.index), cfg_if.data);
            if (cell_if.valid && cell_if.ready)
                life_sb.take_cell(cell_if.cell_alive, cell_if.is_flush);
            if (res_if.valid && res_if.ready) begin
                got.next_alive = res_if.next_alive;
                got.cell_row   = res_if.cell_row;
                got.cell_col   = res_if.cell_col;
                got.last_cell  = res_if.last_cell;
                life_sb.check_cell(got);
            end
        end
    end

    // One cell transaction, preceded by random idle cycles. Valid stays high on return so
    // that back-to-back cells go out at full rate; the next caller lowers it if it idles.
    task automatic send_cell(logic alive, logic flush);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_alive <= alive;
        cell_if.is_flush   <= flush;
        do @(posedge i_clk); while (!cell_if.ready);
        items_sent++;
    endtask

    // Wait until every owed result has come out, then let the pipeline settle, so that any
    // cell still inside that owes no result has passed before the next register write.
    task automatic drain_results();
        cell_if.valid <= 1'b0;
        @(posedge i_clk);
        while (life_sb.pending_cells.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Writes both board sizes back to back; the block must be idle when this is called.
    task automatic set_board(logic [CFG_DATA_W-1:0] cols_val, logic [CFG_DATA_W-1:0] rows_val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_BOARD_COLS;
        cfg_if.data  <= cols_val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= REG_BOARD_ROWS;
        cfg_if.data  <= rows_val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        board_w = next_gen_board::clamp_dim(cols_val, MAX_COLS);
        board_h = next_gen_board::clamp_dim(rows_val[CFG_ROWS_W-1:0], MAX_ROWS);
    endtask

    // A board with random content followed by its flush tail. A count of zero sends the
    // whole board; a smaller count breaks the sequence off early. The noise rate puts the
    // flush flag on board cells and live non-flush cells into the tail.
    task automatic send_board(int unsigned density, int unsigned noise, int unsigned count);
        int unsigned total;
        int unsigned len;
        total = board_w * board_h;
        len   = (count == 0) ? total + board_w + 1 : count;
        for (int unsigned i = 0; i < len; i++) begin
            if (i < total)
                send_cell($urandom_range(99) < density, $urandom_range(99) < noise);
            else if ($urandom_range(99) < noise)
                send_cell(1'b1, 1'b0);
            else
                send_cell(1'($urandom_range(1)), 1'b1);
        end
        boards_run++;
    endtask

    // Mostly complete small boards under fresh sizes, some continuing the stream without a
    // register write, and some broken off partway so the next write restarts mid-board.
    task automatic random_boards(int unsigned goal);
        int unsigned start_cnt;
        int unsigned density;
        int unsigned len;
        start_cnt = items_sent;
        while (items_sent - start_cnt < goal) begin
            if ($urandom_range(7) != 0) begin
                drain_results();
                // Bit 11 of the rows data lies outside the register and must be dropped.
                set_board(CFG_DATA_W'($urandom_range(0, 9)),
                          CFG_DATA_W'($urandom_range(0, 9)) |
                          (($urandom_range(3) == 0) ? 12'h800 : 12'h000));
            end
            case ($urandom_range(3))
                0:       density = 15;
                1:       density = 35;
                2:       density = 50;
                default: density = 80;
            endcase
            len = board_w * board_h + board_w + 1;
            send_board(density, ($urandom_range(2) == 0) ? 0 : 6,
                       ($urandom_range(5) == 0) ? $urandom_range(1, len - 1) : 0);
        end
    endtask

    localparam logic [8:0] BLINKER = 9'b000_111_000;

    initial begin
        // Every block input starts from a known value.
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_BOARD_COLS;
        cfg_if.data        = '0;
        cell_if.valid      = 1'b0;
        cell_if.cell_alive = 1'b0;
        cell_if.is_flush   = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A couple of cells at the reset size sit in the early region of a
        // 2048 x 1024 board and owe nothing.
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b1);
        drain_results();

        // Zero sizes act as a 1 x 1 board: one live cell with no neighbors dies, and the
        // second flush transaction brings it out as the last cell.
        set_board(12'd0, 12'd0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b0, 1'b1);
        drain_results();

        // A blinker on a 3 x 3 board flips from horizontal to vertical, edges masked.
        set_board(12'd3, 12'd3);
        for (int i = 0; i < 9; i++) send_cell(BLINKER[8 - i], 1'b0);
        for (int i = 0; i < 4; i++) send_cell(1'b0, 1'b1);

        // A board broken off after two cells, then restarted by a register write as 2 x 2.
        // The flush flag kills the second board cell, which is then born again; live cells
        // without the flag in the tail lie past the board and count as dead.
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        drain_results();
        set_board(12'd2, 12'd2);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b0);
        for (int i = 0; i < 3; i++) send_cell(1'b1, 1'b0);

        // Random part under the three handshake mixes.
        random_boards(130);
        send_idle_pct = 56;
        recv_idle_pct = 26;
        random_boards(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_boards(130);

        // Short runs into boards at the largest sizes, including values above the maximum.
        // They are broken off early, so only the first rows come out.
        drain_results();
        set_board(12'hFFF, 12'd1);
        send_board(40, 2, 30);
        drain_results();
        set_board(12'd1, 12'hFFF);
        send_board(50, 2, 30);
        drain_results();
        set_board(12'd2, 12'd1024);
        send_board(60, 0, 40);

        drain_results();
        $display("Ran %0d boards, up to 9 x 9 and partial ones at the largest sizes.",
                 boards_run);
        $display("Checked %0d results from %0d cells: %0d board ends, %0d live, %0d mismatches.",
                 life_sb.results_seen, life_sb.cells_taken, life_sb.board_ends,
                 life_sb.live_out, life_sb.mismatches);
        if (life_sb.mismatches == 0 && life_sb.pending_cells.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: the slowest correct run takes well under a tenth of this.
    initial begin
        #2ms;
        $display("Timeout with %0d results still outstanding.", life_sb.pending_cells.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
